// ----- design/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg
// Shared widths, types and helpers for the triangle plane slicer.
// ----------------------------------------------------------------------------
package tps_pkg;

	localparam int CW          = 32;            // coordinate width
	localparam int FRAC_BITS   = 16;            // Q15.16, binary point only
	localparam int DW          = CW + 1;        // difference / magnitude width
	localparam int PW          = 2 * DW;        // product width
	localparam int QW          = CW + 2;        // signed quotient width
	localparam int DIV_STEPS   = DW;            // quotient bits
	localparam int STEPS_PER_STAGE = 3;
	localparam int DIV_STAGES  = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int MD_LAT      = 2 + DIV_STAGES; // magnitude, multiply, divide

	typedef enum logic [1:0] {
		EDGE_AB = 2'd0,
		EDGE_AC = 2'd1,
		EDGE_BC = 2'd2
	} edge_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} vtx_t;

	// per-item control and passthrough coordinates riding beside the dividers
	typedef struct packed {
		logic                 hit;
		logic                 start_cross;
		logic                 end_cross;
		logic signed [CW-1:0] sv_x;
		logic signed [CW-1:0] sv_z;
		logic signed [CW-1:0] ev_x;
		logic signed [CW-1:0] ev_z;
		logic signed [CW-1:0] p0_x;
		logic signed [CW-1:0] p0_z;
		logic signed [CW-1:0] p1_x;
		logic signed [CW-1:0] p1_z;
	} side_t;

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		mag = v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	function automatic logic signed [DW-1:0] sdiff(input logic signed [CW-1:0] p,
			input logic signed [CW-1:0] q);
		sdiff = {p[CW-1], p} - {q[CW-1], q};
	endfunction

endpackage

// ----- design/triangle_plane_slicer_core.sv -----
// ----------------------------------------------------------------------------
// triangle_plane_slicer_core
// Slices one triangle per word with the plane y = plane_height.
// ----------------------------------------------------------------------------
// Pipeline: classify, edge setup, magnitude, multiply, 11-stage divider,
//   output register.
// Throughput: one triangle per cycle; the whole pipeline holds while the
//   output word waits, so the divider chain sets the depth, not the rate.
// Reset: arst_n clears all valid bits and plane_height to 0.
module triangle_plane_slicer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest first)
	input  logic [9*tps_pkg::CW-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// start_x, start_z, end_x, end_z (lowest first)
	output logic [4*tps_pkg::CW-1:0]    m_axis_tdata,
	// hit
	output logic                        m_axis_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	// plane_height
	input  logic [tps_pkg::CW-1:0]      cfg_data
);

	localparam int CW = tps_pkg::CW;
	localparam int DW = tps_pkg::DW;
	localparam int QW = tps_pkg::QW;
	localparam int ML = tps_pkg::MD_LAT;

	logic signed [CW-1:0] h_q;
	logic                 en;

	// global advance: everything moves unless the output word is stuck
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			h_q <= '0;
		else if (cfg_valid)
			h_q <= $signed(cfg_data);
	end

	// ---- stage 1: capture vertices, classify heights against the plane ----
	tps_pkg::vtx_t        vin [3];
	tps_pkg::vtx_t        vtx_s1 [3];
	logic [2:0]           gt_s1, lt_s1, eq_s1;
	logic signed [CW-1:0] h_s1;
	logic                 v_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vin[i].x = $signed(s_axis_tdata[(3*i+0)*CW +: CW]);
			vin[i].y = $signed(s_axis_tdata[(3*i+1)*CW +: CW]);
			vin[i].z = $signed(s_axis_tdata[(3*i+2)*CW +: CW]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vtx_s1[i] <= vin[i];
				gt_s1[i]  <= vin[i].y > h_q;
				lt_s1[i]  <= vin[i].y < h_q;
				eq_s1[i]  <= vin[i].y == h_q;
			end
			h_s1 <= h_q;
		end
	end

	// ---- stage 2: pick endpoints and edges, form the differences ----
	logic [1:0]           cnt;
	logic                 hit;
	tps_pkg::edge_t       e0, e1;
	logic                 sc, ec;
	logic [1:0]           si, ei;
	tps_pkg::vtx_t        p0, q0, p1, q1;
	tps_pkg::side_t       side_n;

	always_comb begin
		cnt = 2'(eq_s1[0]) + 2'(eq_s1[1]) + 2'(eq_s1[2]);
		hit = ((|gt_s1) && (|lt_s1)) || (cnt == 2'd2);
		e0 = tps_pkg::EDGE_AB;
		e1 = tps_pkg::EDGE_AC;
		sc = 1'b0;
		ec = 1'b0;
		si = 2'd0;
		ei = 2'd1;
		if (eq_s1[0] && eq_s1[1]) begin
			si = 2'd0; ei = 2'd1;
		end else if (eq_s1[0] && eq_s1[2]) begin
			si = 2'd0; ei = 2'd2;
		end else if (eq_s1[1] && eq_s1[2]) begin
			si = 2'd1; ei = 2'd2;
		end else if (eq_s1[0]) begin
			// vertex on plane first, opposite edge second
			si = 2'd0; ec = 1'b1; e1 = tps_pkg::EDGE_BC;
		end else if (eq_s1[1]) begin
			si = 2'd1; ec = 1'b1; e1 = tps_pkg::EDGE_AC;
		end else if (eq_s1[2]) begin
			si = 2'd2; ec = 1'b1; e1 = tps_pkg::EDGE_AB;
		end else if (gt_s1[0] == gt_s1[1]) begin
			sc = 1'b1; ec = 1'b1; e0 = tps_pkg::EDGE_AC; e1 = tps_pkg::EDGE_BC;
		end else if (gt_s1[0] == gt_s1[2]) begin
			sc = 1'b1; ec = 1'b1; e0 = tps_pkg::EDGE_AB; e1 = tps_pkg::EDGE_BC;
		end else begin
			sc = 1'b1; ec = 1'b1; e0 = tps_pkg::EDGE_AB; e1 = tps_pkg::EDGE_AC;
		end

		unique case (e0)
			tps_pkg::EDGE_AC: begin p0 = vtx_s1[0]; q0 = vtx_s1[2]; end
			tps_pkg::EDGE_BC: begin p0 = vtx_s1[1]; q0 = vtx_s1[2]; end
			default:          begin p0 = vtx_s1[0]; q0 = vtx_s1[1]; end
		endcase
		unique case (e1)
			tps_pkg::EDGE_AC: begin p1 = vtx_s1[0]; q1 = vtx_s1[2]; end
			tps_pkg::EDGE_BC: begin p1 = vtx_s1[1]; q1 = vtx_s1[2]; end
			default:          begin p1 = vtx_s1[0]; q1 = vtx_s1[1]; end
		endcase

		side_n.hit         = hit;
		side_n.start_cross = sc;
		side_n.end_cross   = ec;
		side_n.sv_x        = vtx_s1[si].x;
		side_n.sv_z        = vtx_s1[si].z;
		side_n.ev_x        = vtx_s1[ei].x;
		side_n.ev_z        = vtx_s1[ei].z;
		side_n.p0_x        = p0.x;
		side_n.p0_z        = p0.z;
		side_n.p1_x        = p1.x;
		side_n.p1_z        = p1.z;
	end

	logic signed [DW-1:0] num0_s2, den0_s2, dx0_s2, dz0_s2;
	logic signed [DW-1:0] num1_s2, den1_s2, dx1_s2, dz1_s2;
	tps_pkg::side_t       side_s2;
	logic                 v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			num0_s2 <= tps_pkg::sdiff(p0.y, h_s1);
			den0_s2 <= tps_pkg::sdiff(p0.y, q0.y);
			dx0_s2  <= tps_pkg::sdiff(p0.x, q0.x);
			dz0_s2  <= tps_pkg::sdiff(p0.z, q0.z);
			num1_s2 <= tps_pkg::sdiff(p1.y, h_s1);
			den1_s2 <= tps_pkg::sdiff(p1.y, q1.y);
			dx1_s2  <= tps_pkg::sdiff(p1.x, q1.x);
			dz1_s2  <= tps_pkg::sdiff(p1.z, q1.z);
			side_s2 <= side_n;
		end
	end

	// ---- stages 3..15: four interpolation quotients ----
	logic signed [QW-1:0] q0x, q0z, q1x, q1z;

	tps_muldiv u_md0x (.clk(clk), .en(en), .num(num0_s2), .dif(dx0_s2), .den(den0_s2), .quo(q0x));
	tps_muldiv u_md0z (.clk(clk), .en(en), .num(num0_s2), .dif(dz0_s2), .den(den0_s2), .quo(q0z));
	tps_muldiv u_md1x (.clk(clk), .en(en), .num(num1_s2), .dif(dx1_s2), .den(den1_s2), .quo(q1x));
	tps_muldiv u_md1z (.clk(clk), .en(en), .num(num1_s2), .dif(dz1_s2), .den(den1_s2), .quo(q1z));

	// control rides beside the dividers
	tps_pkg::side_t side_q [ML];
	logic [ML-1:0]  vd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s2;
			for (int k = 1; k < ML; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			vd_q          <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			v_s1          <= s_axis_tvalid;
			v_s2          <= v_s1;
			vd_q          <= {vd_q[ML-2:0], v_s2};
			m_axis_tvalid <= vd_q[ML-1];
		end
	end

	// ---- output stage: crossing = p - quotient, on-plane vertex as is, zero on miss ----
	function automatic logic [CW-1:0] pick(input logic h, input logic cr,
			input logic signed [CW-1:0] v, input logic signed [CW-1:0] p,
			input logic signed [QW-1:0] q);
		logic signed [QW-1:0] t;
		t = {{(QW-CW){p[CW-1]}}, p} - q;
		if (!h)
			pick = '0;
		else if (cr)
			pick = t[CW-1:0];
		else
			pick = v;
	endfunction

	tps_pkg::side_t sd;
	assign sd = side_q[ML-1];

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tuser <= sd.hit;
			m_axis_tdata <= {
				pick(sd.hit, sd.end_cross,   sd.ev_z, sd.p1_z, q1z),
				pick(sd.hit, sd.end_cross,   sd.ev_x, sd.p1_x, q1x),
				pick(sd.hit, sd.start_cross, sd.sv_z, sd.p0_z, q0z),
				pick(sd.hit, sd.start_cross, sd.sv_x, sd.p0_x, q0x)
			};
		end
	end

	// ---- checks ----
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("miss word carries nonzero coordinates");

	a_ready_tie: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready out of step with output stall");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(vd_q) && $stable(v_s2)))
		else $error("pipeline moved during stall");

	a_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vd_q[ML-1]) |=> m_axis_tvalid)
		else $error("item lost at output stage");

endmodule

// ----- design/tps_muldiv.sv -----
// ----------------------------------------------------------------------------
// tps_muldiv
// Pipelined trunc(num * dif / den), toward zero; zero when den is zero.
// ----------------------------------------------------------------------------
module tps_muldiv (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [tps_pkg::DW-1:0]       num,
	input  logic signed [tps_pkg::DW-1:0]       dif,
	input  logic signed [tps_pkg::DW-1:0]       den,
	output logic signed [tps_pkg::QW-1:0]       quo
);

	localparam int DW = tps_pkg::DW;
	localparam int PW = tps_pkg::PW;
	localparam int NS = tps_pkg::DIV_STAGES;
	localparam int SP = tps_pkg::STEPS_PER_STAGE;

	logic [DW-1:0] a_m1, b_m1, d_m1;
	logic          neg_m1, dz_m1;
	logic [PW-1:0] prod_m2;
	logic [DW-1:0] d_m2;
	logic          neg_m2, dz_m2;

	logic [DW-1:0] rem_d [NS];
	logic [DW-1:0] low_d [NS];
	logic [DW-1:0] quo_d [NS];
	logic [DW-1:0] dv_d  [NS];
	logic          neg_d [NS];
	logic          dz_d  [NS];

	logic [DW-1:0] rem_n [NS];
	logic [DW-1:0] low_n [NS];
	logic [DW-1:0] quo_n [NS];

	always_ff @(posedge clk) begin
		if (en) begin
			a_m1    <= tps_pkg::mag(num);
			b_m1    <= tps_pkg::mag(dif);
			d_m1    <= tps_pkg::mag(den);
			neg_m1  <= num[DW-1] ^ dif[DW-1] ^ den[DW-1];
			dz_m1   <= (den == '0);
			prod_m2 <= PW'(a_m1) * PW'(b_m1);
			d_m2    <= d_m1;
			neg_m2  <= neg_m1;
			dz_m2   <= dz_m1;
		end
	end

	// restoring division, SP quotient bits per stage
	always_comb begin
		logic [DW:0]   t;
		logic [DW-1:0] r, l, q, d;
		for (int k = 0; k < NS; k++) begin
			if (k == 0) begin
				r = prod_m2[PW-1:DW];
				l = prod_m2[DW-1:0];
				q = '0;
				d = d_m2;
			end else begin
				r = rem_d[k-1];
				l = low_d[k-1];
				q = quo_d[k-1];
				d = dv_d[k-1];
			end
			for (int s = 0; s < SP; s++) begin
				if (k * SP + s < tps_pkg::DIV_STEPS) begin
					t = {r, l[DW-1]};
					l = {l[DW-2:0], 1'b0};
					if (t >= {1'b0, d}) begin
						t = t - {1'b0, d};
						q = {q[DW-2:0], 1'b1};
					end else begin
						q = {q[DW-2:0], 1'b0};
					end
					r = t[DW-1:0];
				end
			end
			rem_n[k] = r;
			low_n[k] = l;
			quo_n[k] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				rem_d[k] <= rem_n[k];
				low_d[k] <= low_n[k];
				quo_d[k] <= quo_n[k];
				if (k == 0) begin
					dv_d[k]  <= d_m2;
					neg_d[k] <= neg_m2;
					dz_d[k]  <= dz_m2;
				end else begin
					dv_d[k]  <= dv_d[k-1];
					neg_d[k] <= neg_d[k-1];
					dz_d[k]  <= dz_d[k-1];
				end
			end
		end
	end

	always_comb begin
		if (dz_d[NS-1])
			quo = '0;
		else if (neg_d[NS-1])
			quo = -$signed({1'b0, quo_d[NS-1]});
		else
			quo = $signed({1'b0, quo_d[NS-1]});
	end

endmodule
